[design/coalesced_hash_table_with_cellar_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the hash table core
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef COALESCED_HASH_TABLE_WITH_CELLAR_CORE_DEFINES_SVH
`define COALESCED_HASH_TABLE_WITH_CELLAR_CORE_DEFINES_SVH

// same-cycle implication
`define CHTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/chtc_pkg.sv]
// ----------------------------------------------------------------------------
// chtc_pkg
// Shared types for the coalesced hash table: transaction structs, codes,
// sequencer states and the control structs between top level and sequencer.
// ----------------------------------------------------------------------------
package chtc_pkg;

  localparam int KEY_BITS   = 64;
  localparam int HOME_BITS  = 10;
  localparam int PAY_BITS   = 32;
  localparam int VKIND_BITS = 8;

  typedef enum logic {
    OP_BIND    = 1'b0,
    OP_RESOLVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_BOUND     = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    op_t                   kind;
    logic [KEY_BITS-1:0]   key;
    logic [HOME_BITS-1:0]  home_slot;
    logic [PAY_BITS-1:0]   payload;
    logic [VKIND_BITS-1:0] value_kind;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [PAY_BITS-1:0]   found_payload;
    logic [VKIND_BITS-1:0] found_kind;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_LOOK,
    ST_CHECK,
    ST_SCAN,
    ST_PROBE,
    ST_LINK,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic start;
    logic sink_ready;
  } seq_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_sts_t;

  function automatic rsp_t empty_rsp(status_t s);
    rsp_t r;
    r.status        = s;
    r.found_payload = '0;
    r.found_kind    = '0;
    return r;
  endfunction

endpackage

[design/chtc_ram.sv]
// ----------------------------------------------------------------------------
// chtc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/chtc_seq.sv]
// ----------------------------------------------------------------------------
// chtc_seq
// Sequencer and slot storage: home reduction by repeated subtract, chain
// walk one record per read, cellar probe and link insert, reset clear sweep.
// ----------------------------------------------------------------------------
module chtc_seq import chtc_pkg::*; #(
  parameter int TOTAL_SLOTS   = 1024,
  parameter int PRIMARY_SLOTS = 880,
  parameter int KEY_WIDTH     = 64,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  seq_ctl_t ctl,
  input  req_t     req,
  output seq_sts_t sts,
  output rsp_t     rsp
);

  localparam int AW = $clog2(TOTAL_SLOTS);
  localparam int LW = AW + 1;
  localparam int CW = AW + 1;
  localparam int MW = LW + 1;
  localparam int DW = KEY_WIDTH + PAYLOAD_WIDTH + VKIND_BITS;
  localparam bit NEED_RED = PRIMARY_SLOTS < (1 << HOME_BITS);
  localparam logic [HOME_BITS-1:0] PRIM_H = HOME_BITS'(NEED_RED ? PRIMARY_SLOTS : 0);
  localparam logic [CW-1:0] TOTAL_C = CW'(TOTAL_SLOTS);
  localparam logic [LW-1:0] TOTAL_L = LW'(TOTAL_SLOTS);
  localparam logic [CW-1:0] CUR_INIT =
    CW'(PRIMARY_SLOTS < TOTAL_SLOTS ? PRIMARY_SLOTS : TOTAL_SLOTS);
  localparam logic [LW-1:0] LINK_END = '1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TOTAL_SLOTS - 1);

  seq_state_t               state, state_next;
  op_t                      op, op_next;
  logic [KEY_WIDTH-1:0]     key, key_next;
  logic [PAYLOAD_WIDTH-1:0] pay, pay_next;
  logic [VKIND_BITS-1:0]    vkind, vkind_next;
  logic [HOME_BITS-1:0]     home, home_next;
  logic [AW-1:0]            cur, cur_next;
  logic [AW-1:0]            tail, tail_next;
  logic [AW-1:0]            cand, cand_next;
  logic [CW-1:0]            steps, steps_next;
  logic [CW-1:0]            cursor, cursor_next;
  logic [CW-1:0]            used_count, used_count_next;
  logic [AW-1:0]            clr_addr, clr_addr_next;
  rsp_t                     rsp_q, rsp_next;

  logic          meta_we, data_we;
  logic [AW-1:0] waddr, raddr;
  logic [MW-1:0] meta_wdata, meta_rdata;
  logic [DW-1:0] data_wdata, data_rdata;

  logic          rd_used, key_eq, home_big, nx_stop;
  logic [LW-1:0] rd_link;
  logic [CW-1:0] steps_inc;

  chtc_ram #(.WIDTH(MW), .DEPTH(TOTAL_SLOTS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (waddr),
    .wdata (meta_wdata),
    .raddr (raddr),
    .rdata (meta_rdata)
  );

  chtc_ram #(.WIDTH(DW), .DEPTH(TOTAL_SLOTS)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (waddr),
    .wdata (data_wdata),
    .raddr (raddr),
    .rdata (data_rdata)
  );

  assign rd_used   = meta_rdata[MW-1];
  assign rd_link   = meta_rdata[LW-1:0];
  assign key_eq    = data_rdata[VKIND_BITS+PAYLOAD_WIDTH +: KEY_WIDTH] == key;
  assign home_big  = 32'(home) >= 32'(TOTAL_SLOTS);
  assign steps_inc = steps + CW'(1);
  assign nx_stop   = (rd_link >= TOTAL_L) || (steps_inc >= TOTAL_C);
  assign rsp       = rsp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      cursor     <= CUR_INIT;
      used_count <= '0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      cursor     <= cursor_next;
      used_count <= used_count_next;
    end
  end

  always_ff @(posedge clk) begin
    op    <= op_next;
    key   <= key_next;
    pay   <= pay_next;
    vkind <= vkind_next;
    home  <= home_next;
    cur   <= cur_next;
    tail  <= tail_next;
    cand  <= cand_next;
    steps <= steps_next;
    rsp_q <= rsp_next;
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    key_next        = key;
    pay_next        = pay;
    vkind_next      = vkind;
    home_next       = home;
    cur_next        = cur;
    tail_next       = tail;
    cand_next       = cand;
    steps_next      = steps;
    cursor_next     = cursor;
    used_count_next = used_count;
    clr_addr_next   = clr_addr;
    rsp_next        = rsp_q;
    meta_we         = 1'b0;
    data_we         = 1'b0;
    waddr           = cur;
    raddr           = cur;
    meta_wdata      = '0;
    data_wdata      = {key, pay, vkind};
    sts.idle        = 1'b0;
    sts.done        = 1'b0;

    case (state)
      ST_CLEAR: begin
        meta_we       = 1'b1;
        waddr         = clr_addr;
        meta_wdata    = {1'b0, LINK_END};
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        sts.idle = 1'b1;
        if (ctl.start) begin
          op_next    = req.kind;
          key_next   = KEY_WIDTH'(req.key);
          pay_next   = PAYLOAD_WIDTH'(req.payload);
          vkind_next = req.value_kind;
          home_next  = req.home_slot;
          steps_next = '0;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (NEED_RED && home >= PRIM_H) begin
          home_next = home - PRIM_H;
        end else if (op == OP_BIND && (used_count >= TOTAL_C || home_big)) begin
          rsp_next   = empty_rsp(STAT_FULL);
          state_next = ST_DONE;
        end else if (home_big) begin
          rsp_next   = empty_rsp(STAT_NOT_FOUND);
          state_next = ST_DONE;
        end else begin
          cur_next   = AW'(home);
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (op == OP_BIND) begin
          if (steps == '0 && !rd_used) begin
            meta_we         = 1'b1;
            data_we         = 1'b1;
            meta_wdata      = {1'b1, rd_link};
            used_count_next = used_count + CW'(1);
            rsp_next        = empty_rsp(STAT_OK);
            state_next      = ST_DONE;
          end else if (key_eq) begin
            rsp_next   = empty_rsp(STAT_BOUND);
            state_next = ST_DONE;
          end else if (nx_stop) begin
            tail_next  = cur;
            state_next = ST_SCAN;
          end else begin
            cur_next   = rd_link[AW-1:0];
            steps_next = steps_inc;
            state_next = ST_LOOK;
          end
        end else begin
          if (!rd_used) begin
            rsp_next   = empty_rsp(STAT_NOT_FOUND);
            state_next = ST_DONE;
          end else if (key_eq) begin
            rsp_next.status        = STAT_OK;
            rsp_next.found_payload = PAY_BITS'(data_rdata[VKIND_BITS +: PAYLOAD_WIDTH]);
            rsp_next.found_kind    = data_rdata[VKIND_BITS-1:0];
            state_next             = ST_DONE;
          end else if (nx_stop) begin
            rsp_next   = empty_rsp(STAT_NOT_FOUND);
            state_next = ST_DONE;
          end else begin
            cur_next   = rd_link[AW-1:0];
            steps_next = steps_inc;
            state_next = ST_LOOK;
          end
        end
      end
      ST_SCAN: begin
        if (cursor >= TOTAL_C) begin
          rsp_next   = empty_rsp(STAT_FULL);
          state_next = ST_DONE;
        end else begin
          raddr       = cursor[AW-1:0];
          cand_next   = cursor[AW-1:0];
          cursor_next = cursor + CW'(1);
          state_next  = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (!rd_used) begin
          meta_we    = 1'b1;
          data_we    = 1'b1;
          waddr      = cand;
          meta_wdata = {1'b1, rd_link};
          state_next = ST_LINK;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_LINK: begin
        meta_we         = 1'b1;
        waddr           = tail;
        meta_wdata      = {1'b1, LW'(cand)};
        used_count_next = used_count + CW'(1);
        rsp_next        = empty_rsp(STAT_OK);
        state_next      = ST_DONE;
      end
      ST_DONE: begin
        if (ctl.sink_ready) begin
          sts.done   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[design/coalesced_hash_table_with_cellar_core.sv]
// ----------------------------------------------------------------------------
// coalesced_hash_table_with_cellar_core
// Flow: home reduction by repeated subtract, then a chain walk, one record per read;
// a cellar insert adds a probe read per cellar slot tried, then a final link write.
// One transaction at a time: each chain record costs one slot RAM read.
// Reset (sync): sweep clearing occupancy and links, req_stall high.
// ----------------------------------------------------------------------------
module coalesced_hash_table_with_cellar_core import chtc_pkg::*; #(
  parameter int TOTAL_SLOTS   = 1024,
  parameter int PRIMARY_SLOTS = 880,
  parameter int KEY_WIDTH     = 64,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  seq_ctl_t ctl;
  seq_sts_t sts;
  rsp_t     seq_rsp;

  assign req_stall      = !sts.idle;
  assign ctl.start      = req_valid && sts.idle;
  assign ctl.sink_ready = !rsp_valid || !rsp_stall;

  chtc_seq #(
    .TOTAL_SLOTS   (TOTAL_SLOTS),
    .PRIMARY_SLOTS (PRIMARY_SLOTS),
    .KEY_WIDTH     (KEY_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_seq (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .req (req),
    .sts (sts),
    .rsp (seq_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (sts.done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.done) begin
      rsp <= seq_rsp;
    end
  end

endmodule

[design/chtc_checker.sv]
// ----------------------------------------------------------------------------
// chtc_checker
// Port-level checks for the hash table core, bound to the top level.
// ----------------------------------------------------------------------------
`include "coalesced_hash_table_with_cellar_core_defines.svh"

module chtc_checker import chtc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  `CHTC_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accepted while busy")
  `CHTC_ASSERT_NOW(a_zero_on_fail, rsp_valid && rsp.status != STAT_OK, rsp.found_payload == '0 && rsp.found_kind == '0, "nonzero value on failed transaction")
  `CHTC_ASSERT_NOW(a_rsp_from_busy, $rose(rsp_valid), $past(req_stall), "result without work in progress")
  `CHTC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")

endmodule

bind coalesced_hash_table_with_cellar_core chtc_checker u_checker (.*);

[tb/coalesced_hash_table_with_cellar_core_test.sv]
// ----------------------------------------------------------------------------
// coalesced_hash_table_with_cellar_core_test
// Self-checking bench for the cellar hash table. Binds and resolves go in
// through a randomly paced driver, results come out under random stall. A
// behavioral copy of the table predicts each result, and the monitor checks
// each result in order. The run grows chains into the cellar, exhausts the
// cellar and then fills the table completely.
// ----------------------------------------------------------------------------
module coalesced_hash_table_with_cellar_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import chtc_pkg::*;

  localparam int TOTAL_SLOTS   = 1024;
  localparam int PRIMARY_SLOTS = 880;
  localparam int CELLAR_SLOTS  = TOTAL_SLOTS - PRIMARY_SLOTS;
  localparam int CHAIN_END     = 2047;
  localparam int QUIET_LIMIT   = 20000;
  localparam int HOT_COUNT     = 24;
  localparam logic [KEY_BITS-1:0] KEY_A = 64'hA5A5_0F0F_3C3C_9696;
  localparam logic [KEY_BITS-1:0] KEY_B = 64'h0123_4567_89AB_CDEF;

  typedef struct {
    logic [KEY_BITS-1:0] key;
    int                  home;
  } ident_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_stall = 1'b0;
  req_t req       = '0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  // table image
  bit                    slot_used [TOTAL_SLOTS];
  logic [KEY_BITS-1:0]   slot_key  [TOTAL_SLOTS];
  logic [PAY_BITS-1:0]   slot_pay  [TOTAL_SLOTS];
  logic [VKIND_BITS-1:0] slot_kind [TOTAL_SLOTS];
  int                    chain_link[TOTAL_SLOTS];
  int                    cellar_cursor;
  int                    used_count;

  ident_t idents[$];
  req_t   backlog[$];
  rsp_t   answers_due[$];
  rsp_t   oldest_due;
  int     hot_homes[HOT_COUNT];
  int     mismatches = 0;
  int     req_wait = 0;
  int     rsp_wait = 0;
  int     quiet = 0;
  bit     req_calm = 1'b0;
  bit     rsp_calm = 1'b0;

  coalesced_hash_table_with_cellar_core #(
    .TOTAL_SLOTS  (TOTAL_SLOTS),
    .PRIMARY_SLOTS(PRIMARY_SLOTS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #1 clk = ~clk;

  function automatic rsp_t table_access(req_t r);
    int   home;
    int   cur;
    int   nx;
    int   steps;
    int   target;
    bit   dup;
    rsp_t a;
    a.status        = STAT_OK;
    a.found_payload = '0;
    a.found_kind    = '0;
    home   = int'(r.home_slot) % PRIMARY_SLOTS;
    target = -1;
    if (r.kind == OP_BIND) begin
      if (used_count >= TOTAL_SLOTS) begin
        a.status = STAT_FULL;
      end else if (!slot_used[home]) begin
        target = home;
      end else begin
        cur   = home;
        steps = 0;
        dup   = 1'b0;
        while (1) begin
          if (slot_key[cur] == r.key) begin
            dup = 1'b1;
            break;
          end
          nx = chain_link[cur];
          steps++;
          if (nx >= TOTAL_SLOTS || steps >= TOTAL_SLOTS) break;
          cur = nx;
        end
        if (dup) begin
          a.status = STAT_BOUND;
        end else begin
          while (cellar_cursor < TOTAL_SLOTS && target < 0) begin
            if (!slot_used[cellar_cursor]) target = cellar_cursor;
            cellar_cursor++;
          end
          if (target < 0) a.status = STAT_FULL;
          else chain_link[cur] = target;
        end
      end
      if (target >= 0) begin
        slot_used[target] = 1'b1;
        slot_key[target]  = r.key;
        slot_pay[target]  = r.payload;
        slot_kind[target] = r.value_kind;
        used_count++;
      end
    end else begin
      a.status = STAT_NOT_FOUND;
      cur      = home;
      steps    = 0;
      while (cur < TOTAL_SLOTS && steps < TOTAL_SLOTS && slot_used[cur]) begin
        if (slot_key[cur] == r.key) begin
          a.status        = STAT_OK;
          a.found_payload = slot_pay[cur];
          a.found_kind    = slot_kind[cur];
          break;
        end
        cur = chain_link[cur];
        steps++;
      end
    end
    return a;
  endfunction

  function automatic int pause_len(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [KEY_BITS-1:0] fresh_key();
    return {$urandom, $urandom};
  endfunction

  // homes below CELLAR_SLOTS are sometimes sent in their unreduced, cellar-range form
  function automatic int home_code(int h);
    return (h < CELLAR_SLOTS && $urandom_range(0, 2) == 0) ? h + PRIMARY_SLOTS : h;
  endfunction

  function automatic int new_home();
    return ($urandom_range(0, 9) < 7) ? hot_homes[$urandom_range(0, HOT_COUNT - 1)]
                                      : $urandom_range(0, PRIMARY_SLOTS - 1);
  endfunction

  task automatic push_item(op_t op, logic [KEY_BITS-1:0] key, int home,
                           logic [PAY_BITS-1:0] pay, logic [VKIND_BITS-1:0] vk);
    req_t   r;
    ident_t id;
    r.kind       = op;
    r.key        = key;
    r.home_slot  = home[HOME_BITS-1:0];
    r.payload    = pay;
    r.value_kind = vk;
    backlog.push_back(r);
    if (op == OP_BIND) begin
      id.key  = key;
      id.home = home % PRIMARY_SLOTS;
      idents.push_back(id);
    end
  endtask

  task automatic push_mixed(int n);
    ident_t id;
    int     r;
    int     h;
    for (int i = 0; i < n; i++) begin
      r  = $urandom_range(0, 99);
      id = idents[$urandom_range(0, idents.size() - 1)];
      if (r < 45) begin
        if ($urandom_range(0, 3) != 0) begin
          h = ($urandom_range(0, 19) == 0) ? $urandom_range(0, TOTAL_SLOTS - 1)
                                           : home_code(new_home());
          push_item(OP_BIND, fresh_key(), h, $urandom, 8'($urandom));
        end else begin
          push_item(OP_BIND, id.key, home_code(id.home), $urandom, 8'($urandom));
        end
      end else if (r < 90) begin
        push_item(OP_RESOLVE, id.key, home_code(id.home), $urandom, 8'($urandom));
      end else begin
        push_item(OP_RESOLVE, fresh_key(), $urandom_range(0, TOTAL_SLOTS - 1),
                  $urandom, 8'($urandom));
      end
    end
  endtask

  task automatic wait_all_answered();
    while (backlog.size() != 0 || req_valid || answers_due.size() != 0)
      @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (req_valid) req_wait = pause_len(req_calm);
      if (req_wait > 0) begin
        req_wait--;
        req_valid <= 1'b0;
      end else if (backlog.size() != 0) begin
        req       <= backlog.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) rsp_wait = pause_len(rsp_calm);
      else if (rsp_wait > 0) rsp_wait--;
      rsp_stall <= (rsp_wait > 0);
    end
  end

  // monitor: check results first, then predict the newly accepted transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, rsp);
          mismatches++;
        end else begin
          oldest_due = answers_due.pop_front();
          if (rsp.status !== oldest_due.status) begin
            $display("%0t: status expected %0d, got %0d", $time, oldest_due.status,
                     rsp.status);
            mismatches++;
          end
          if (rsp.found_payload !== oldest_due.found_payload) begin
            $display("%0t: found_payload expected %h, got %h", $time,
                     oldest_due.found_payload, rsp.found_payload);
            mismatches++;
          end
          if (rsp.found_kind !== oldest_due.found_kind) begin
            $display("%0t: found_kind expected %h, got %h", $time,
                     oldest_due.found_kind, rsp.found_kind);
            mismatches++;
          end
        end
      end
      if (req_valid && !req_stall) answers_due.push_back(table_access(req));
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int need;
    ident_t id;
    for (int i = 0; i < TOTAL_SLOTS; i++) begin
      slot_used[i]  = 1'b0;
      chain_link[i] = CHAIN_END;
    end
    cellar_cursor = PRIMARY_SLOTS;
    used_count    = 0;
    foreach (hot_homes[i]) hot_homes[i] = $urandom_range(0, PRIMARY_SLOTS - 1);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed
    push_item(OP_RESOLVE, '0, 0, 32'h1234_5678, 8'h5A);
    push_item(OP_BIND, '0, 0, '1, '1);
    push_item(OP_RESOLVE, '0, 0, '0, '0);
    push_item(OP_BIND, '1, PRIMARY_SLOTS - 1, '0, '0);
    push_item(OP_BIND, KEY_A, PRIMARY_SLOTS, 32'hDEAD_BEEF, 8'h81);
    push_item(OP_BIND, KEY_A ^ 64'h1, 0, 32'h0000_0001, 8'h01);
    push_item(OP_BIND, '0, 0, 32'h5555_5555, 8'h55);
    push_item(OP_BIND, KEY_A, 0, 32'hAAAA_AAAA, 8'hAA);
    push_item(OP_RESOLVE, KEY_A, PRIMARY_SLOTS, '0, '0);
    push_item(OP_RESOLVE, KEY_A ^ 64'h1, 0, '0, '0);
    push_item(OP_RESOLVE, KEY_A ^ {1'b1, 63'b0}, 0, '0, '0);
    push_item(OP_RESOLVE, '1, PRIMARY_SLOTS - 1, '1, '1);
    push_item(OP_RESOLVE, '1, 0, '0, '0);
    push_item(OP_BIND, KEY_B, TOTAL_SLOTS - 1, 32'h8000_0000, 8'h80);
    push_item(OP_RESOLVE, KEY_B, CELLAR_SLOTS - 1, '0, '0);
    push_item(OP_RESOLVE, KEY_B, TOTAL_SLOTS - 1, '0, '0);
    push_item(OP_BIND, KEY_B, TOTAL_SLOTS - 1, 32'h7FFF_FFFF, 8'h7F);
    push_item(OP_RESOLVE, '0, PRIMARY_SLOTS, '0, '0);

    // chains grow into the cellar
    push_mixed(550);
    wait_all_answered();

    // use up the cellar, then a few binds that find it exhausted
    need = TOTAL_SLOTS - cellar_cursor;
    for (int i = 0; i < need + 3; i++) begin
      id = idents[$urandom_range(0, idents.size() - 1)];
      push_item(OP_BIND, fresh_key(), home_code(id.home), $urandom, 8'($urandom));
    end
    wait_all_answered();

    // fill every free primary slot, with lookups mixed in
    for (int s = 0; s < PRIMARY_SLOTS; s++) begin
      if (!slot_used[s]) push_item(OP_BIND, fresh_key(), home_code(s), $urandom,
                                   8'($urandom));
      if ($urandom_range(0, 7) == 0) begin
        id = idents[$urandom_range(0, idents.size() - 1)];
        push_item(OP_RESOLVE, id.key, home_code(id.home), $urandom, 8'($urandom));
      end
    end
    wait_all_answered();

    // table full
    push_mixed(90);
    wait_all_answered();
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
